>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
// Bodies sample on clk and are disabled while arst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QSM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/qsm_pkg.sv
// Shared widths, types and constants for the quaternion to model matrix pipeline.
// No dependencies.
package qsm_pkg;

	localparam int Q_W         = 32;
	localparam int PROD_W      = 2 * Q_W;
	localparam int ENTRY_W     = PROD_W + 1;
	localparam int MAG_W       = PROD_W;
	localparam int HALF_W      = MAG_W / 2;
	localparam int FULL_W      = MAG_W + Q_W;
	localparam int FRAC_SHIFT  = 59;
	localparam int QUO_W       = FULL_W - 1 - FRAC_SHIFT;
	localparam int NUM_ENTRIES = 9;
	localparam int NUM_AXES    = 3;

	typedef logic signed [Q_W-1:0]     coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [QUO_W-1:0]          quo_t;

	// 1.0 in units of 2^-59
	localparam entry_t ONE_Q59    = entry_t'(65'h0_0800_0000_0000_0000);
	// half of one output LSB in units of 2^-75
	localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (FRAC_SHIFT - 1);
	localparam quo_t   NEG_LIMIT  = quo_t'(36'h0_8000_0000);
	localparam quo_t   POS_LIMIT  = quo_t'(36'h0_7FFF_FFFF);
	localparam coord_t NEG_SAT    = coord_t'(32'h8000_0000);
	localparam coord_t POS_SAT    = coord_t'(32'h7FFF_FFFF);

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} adv_t;

endpackage

>>> src/quaternion_scale_to_model_matrix_top.sv
// Top level: quaternion, scale and position to a scaled 3x3 model matrix.
// Depends on qsm_pkg, qsm_rot_stage, qsm_scale_lane and assert_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | quat_x..quat_w, scale_x..z, pos_x..z
//  out     | out_valid / out_ready| entry_0_0..entry_2_2, trans_x..trans_z
//
// One request per cycle is sustained while out_ready does not stall the output.
// The 64x32 scale product is split into two 32x32 partials, which sets the depth.
// Reset clears only the stage valid bits; data registers are left as they are.
// A stall at the output holds the last stage; earlier stages keep filling
// empty slots, so in_ready stays high while any stage is free.
`include "assert_macros.svh"

module quaternion_scale_to_model_matrix_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qsm_pkg::coord_t quat_x,
	input  qsm_pkg::coord_t quat_y,
	input  qsm_pkg::coord_t quat_z,
	input  qsm_pkg::coord_t quat_w,
	input  qsm_pkg::coord_t scale_x,
	input  qsm_pkg::coord_t scale_y,
	input  qsm_pkg::coord_t scale_z,
	input  qsm_pkg::coord_t pos_x,
	input  qsm_pkg::coord_t pos_y,
	input  qsm_pkg::coord_t pos_z,
	output logic            out_valid,
	input  logic            out_ready,
	output qsm_pkg::coord_t entry_0_0,
	output qsm_pkg::coord_t entry_0_1,
	output qsm_pkg::coord_t entry_0_2,
	output qsm_pkg::coord_t entry_1_0,
	output qsm_pkg::coord_t entry_1_1,
	output qsm_pkg::coord_t entry_1_2,
	output qsm_pkg::coord_t entry_2_0,
	output qsm_pkg::coord_t entry_2_1,
	output qsm_pkg::coord_t entry_2_2,
	output qsm_pkg::coord_t trans_x,
	output qsm_pkg::coord_t trans_y,
	output qsm_pkg::coord_t trans_z
);
	import qsm_pkg::*;

	adv_t   adv;
	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	coord_t scale_s1 [NUM_AXES];
	coord_t scale_s2 [NUM_AXES];
	coord_t pos_s1 [NUM_AXES];
	coord_t pos_s2 [NUM_AXES];
	coord_t pos_s3 [NUM_AXES];
	coord_t pos_s4 [NUM_AXES];
	coord_t pos_s5 [NUM_AXES];
	coord_t pos_s6 [NUM_AXES];
	entry_t entry_s2 [NUM_ENTRIES];
	coord_t res_s6 [NUM_ENTRIES];

	// a stage loads when it is empty or its content moves on
	always_comb begin
		adv.s6   = !vld_s6 || out_ready;
		adv.s5   = !vld_s5 || adv.s6;
		adv.s4   = !vld_s4 || adv.s5;
		adv.s3   = !vld_s3 || adv.s4;
		adv.s2   = !vld_s2 || adv.s3;
		adv.s1   = !vld_s1 || adv.s2;
		in_ready = adv.s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= in_valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			if (adv.s4) vld_s4 <= vld_s3;
			if (adv.s5) vld_s5 <= vld_s4;
			if (adv.s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			scale_s1[0] <= scale_x;
			scale_s1[1] <= scale_y;
			scale_s1[2] <= scale_z;
			pos_s1[0]   <= pos_x;
			pos_s1[1]   <= pos_y;
			pos_s1[2]   <= pos_z;
		end
		if (adv.s2) begin
			scale_s2 <= scale_s1;
			pos_s2   <= pos_s1;
		end
		if (adv.s3) pos_s3 <= pos_s2;
		if (adv.s4) pos_s4 <= pos_s3;
		if (adv.s5) pos_s5 <= pos_s4;
		if (adv.s6) pos_s6 <= pos_s5;
	end

	qsm_rot_stage u_rot (
		.clk      (clk),
		.adv      (adv),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.quat_w   (quat_w),
		.entry_s2 (entry_s2)
	);

	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_lane
		localparam int ROW = i / NUM_AXES;
		qsm_scale_lane u_lane (
			.clk      (clk),
			.adv      (adv),
			.entry_s2 (entry_s2[i]),
			.scale_s2 (scale_s2[ROW]),
			.res_s6   (res_s6[i])
		);
	end

	assign out_valid = vld_s6;
	assign entry_0_0 = res_s6[0];
	assign entry_0_1 = res_s6[1];
	assign entry_0_2 = res_s6[2];
	assign entry_1_0 = res_s6[3];
	assign entry_1_1 = res_s6[4];
	assign entry_1_2 = res_s6[5];
	assign entry_2_0 = res_s6[6];
	assign entry_2_1 = res_s6[7];
	assign entry_2_2 = res_s6[8];
	assign trans_x   = pos_s6[0];
	assign trans_y   = pos_s6[1];
	assign trans_z   = pos_s6[2];

	`QSM_ASSERT_IMPLY(a_full_stall_blocks_input, vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && !out_ready, !in_ready, "request taken into a full stalled pipeline")
	`QSM_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, vld_s1, "accepted request missing from stage 1")
	`QSM_ASSERT_NEXT(a_stalled_s5_kept, vld_s5 && vld_s6 && !out_ready, vld_s5 && vld_s6, "stalled item dropped from stage 5")

endmodule

>>> src/qsm_rot_stage.sv
// Rotation part: nine quaternion products (stage 1) and the nine exact
// rotation entries in units of 2^-59 (stage 2). Depends on qsm_pkg.
module qsm_rot_stage (
	input  logic          clk,
	input  qsm_pkg::adv_t adv,
	input  qsm_pkg::coord_t quat_x,
	input  qsm_pkg::coord_t quat_y,
	input  qsm_pkg::coord_t quat_z,
	input  qsm_pkg::coord_t quat_w,
	output qsm_pkg::entry_t entry_s2 [qsm_pkg::NUM_ENTRIES]
);
	import qsm_pkg::*;

	prod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
		end
	end

	// sums of two products reach +2^63, so keep one extra bit
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			entry_s2[0] <= ONE_Q59 - (entry_t'(yy_s1) + entry_t'(zz_s1));
			entry_s2[1] <= entry_t'(xy_s1) + entry_t'(wz_s1);
			entry_s2[2] <= entry_t'(xz_s1) - entry_t'(wy_s1);
			entry_s2[3] <= entry_t'(xy_s1) - entry_t'(wz_s1);
			entry_s2[4] <= ONE_Q59 - (entry_t'(xx_s1) + entry_t'(zz_s1));
			entry_s2[5] <= entry_t'(yz_s1) + entry_t'(wx_s1);
			entry_s2[6] <= entry_t'(xz_s1) + entry_t'(wy_s1);
			entry_s2[7] <= entry_t'(yz_s1) - entry_t'(wx_s1);
			entry_s2[8] <= ONE_Q59 - (entry_t'(xx_s1) + entry_t'(yy_s1));
		end
	end

endmodule

>>> src/qsm_scale_lane.sv
// One matrix entry times its row scale: magnitudes (stage 3), two 32x32
// partial products (stage 4), round (stage 5), saturate (stage 6). Depends on qsm_pkg.
module qsm_scale_lane (
	input  logic            clk,
	input  qsm_pkg::adv_t   adv,
	input  qsm_pkg::entry_t entry_s2,
	input  qsm_pkg::coord_t scale_s2,
	output qsm_pkg::coord_t res_s6
);
	import qsm_pkg::*;

	logic                  ent_neg;
	entry_t                ent_abs;
	logic signed [Q_W:0]   scale_ext;
	logic signed [Q_W:0]   scale_abs;
	logic [FULL_W-1:0]     sum;
	quo_t                  neg_q;

	mag_t              mag_s3;
	logic [Q_W-1:0]    smag_s3;
	logic              neg_s3, neg_s4, neg_s5;
	logic [PROD_W-1:0] plo_s4, phi_s4;
	quo_t              q_s5;

	always_comb begin
		ent_neg   = entry_s2[ENTRY_W-1];
		ent_abs   = ent_neg ? -entry_s2 : entry_s2;
		scale_ext = {scale_s2[Q_W-1], scale_s2};
		scale_abs = scale_s2[Q_W-1] ? -scale_ext : scale_ext;
		sum       = {{Q_W{1'b0}}, plo_s4} + {phi_s4, {HALF_W{1'b0}}} + ROUND_HALF;
		neg_q     = quo_t'(0) - q_s5;
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			mag_s3  <= ent_abs[MAG_W-1:0];
			smag_s3 <= scale_abs[Q_W-1:0];
			neg_s3  <= ent_neg ^ scale_s2[Q_W-1];
		end
		if (adv.s4) begin
			plo_s4 <= mag_s3[HALF_W-1:0] * smag_s3;
			phi_s4 <= mag_s3[MAG_W-1:HALF_W] * smag_s3;
			neg_s4 <= neg_s3;
		end
		if (adv.s5) begin
			q_s5   <= sum[FRAC_SHIFT +: QUO_W];
			neg_s5 <= neg_s4;
		end
		if (adv.s6) begin
			if (neg_s5) begin
				res_s6 <= (q_s5 > NEG_LIMIT) ? NEG_SAT : coord_t'(neg_q[Q_W-1:0]);
			end else begin
				res_s6 <= (q_s5 > POS_LIMIT) ? POS_SAT : coord_t'(q_s5[Q_W-1:0]);
			end
		end
	end

endmodule
